[src/iicb_pkg.sv]
// shared types and constants for the inverted index counting build unit
package iicb_pkg;

  localparam int TERMS  = 1024;
  localparam int TOKENS = 4096;
  localparam int TW     = $clog2(TERMS);
  localparam int XW     = $clog2(TOKENS);
  localparam int CW     = XW + 1;
  localparam int DOCW   = 16;
  localparam int POSW   = 10;
  localparam int ENTW   = DOCW + POSW;
  localparam int STGW   = TW + ENTW;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_BUILD = 3'd1,
    CMD_RDENT = 3'd2,
    CMD_RDTRM = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_PHASE = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // which operation the datapath performs on its memories this cycle
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_ADD_RD,
    OP_ADD_WR,
    OP_RDENT,
    OP_RDTRM,
    OP_CLR,
    OP_PSUM,
    OP_SCAT
  } op_t;

  typedef struct packed {
    op_t          op;
    logic         step;     // advance sweep pointer
    logic         first;    // reset sweep pointer and accumulator
    logic [1:0]   phase;    // scatter sub-step
  } ctrl_t;

  typedef struct packed {
    logic         sweep_done;
    logic [CW-1:0] total;
  } stat_t;

endpackage

[src/iicb_ram.sv]
// generic single-port write, single-port registered read ram
module iicb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/iicb_datapath.sv]
// memories, sweep pointer and prefix accumulator of the index builder
module iicb_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  iicb_pkg::ctrl_t              ctrl,
  output iicb_pkg::stat_t              stat,
  input  logic                         total_clr,
  input  logic                         total_inc,
  input  logic [iicb_pkg::TW-1:0]      in_term_id,
  input  logic [iicb_pkg::DOCW-1:0]    in_doc_id,
  input  logic [iicb_pkg::POSW-1:0]    in_token_pos,
  input  logic [iicb_pkg::XW-1:0]      in_entry_index,
  output logic [iicb_pkg::ENTW-1:0]    ent_q,
  output logic [iicb_pkg::CW-1:0]      start_q,
  output logic [iicb_pkg::CW-1:0]      count_q
);
  localparam int TW = iicb_pkg::TW;
  localparam int XW = iicb_pkg::XW;
  localparam int CW = iicb_pkg::CW;

  logic [XW:0]    ptr_r, ptr_nxt;       // wide enough to hold the sweep length
  logic [CW-1:0]  acc_r, acc_nxt;
  logic [CW-1:0]  total_r, total_nxt;
  logic [TW-1:0]  tok_term_r, tok_term_nxt;
  logic [iicb_pkg::ENTW-1:0] tok_ent_r, tok_ent_nxt;
  logic [iicb_pkg::STGW-1:0] add_r, add_nxt;   // token of the accepted add item

  logic           cnt_we, st_we, cur_we, stg_we, lst_we;
  logic [TW-1:0]  cnt_wa, cnt_ra, st_wa, st_ra, cur_wa, cur_ra;
  logic [CW-1:0]  cnt_wd, st_wd, cur_wd, cur_q;
  logic [XW-1:0]  stg_wa, stg_ra, lst_wa, lst_ra;
  logic [iicb_pkg::STGW-1:0] stg_wd, stg_q;
  logic [iicb_pkg::ENTW-1:0] lst_wd;

  always_comb begin
    cnt_we = 1'b0; cnt_wa = add_r[iicb_pkg::STGW-1 -: TW]; cnt_wd = count_q + CW'(1);
    cnt_ra = in_term_id;
    st_we  = 1'b0; st_wa  = ptr_r[TW-1:0]; st_wd = acc_r;        st_ra  = in_term_id;
    cur_we = 1'b0; cur_wa = ptr_r[TW-1:0]; cur_wd = acc_r;       cur_ra = tok_term_r;
    stg_we = 1'b0; stg_wa = total_r[XW-1:0];
    stg_wd = add_r;                                              stg_ra = ptr_r[XW-1:0];
    lst_we = 1'b0; lst_wa = cur_q[XW-1:0]; lst_wd = tok_ent_r;   lst_ra = in_entry_index;
    ptr_nxt = ptr_r; acc_nxt = acc_r;
    tok_term_nxt = tok_term_r; tok_ent_nxt = tok_ent_r;
    add_nxt = add_r;
    case (ctrl.op)
      iicb_pkg::OP_ADD_RD: begin
        add_nxt = {in_term_id, in_doc_id, in_token_pos};
      end
      iicb_pkg::OP_ADD_WR: begin
        cnt_we = 1'b1;
        stg_we = 1'b1;
      end
      iicb_pkg::OP_CLR: begin
        cnt_we = 1'b1;
        cnt_wa = ptr_r[TW-1:0];
        cnt_wd = '0;
        if (ctrl.step) ptr_nxt = ptr_r + 1'b1;
      end
      iicb_pkg::OP_PSUM: begin
        // the registered count of ptr arrives in the cycle after its read address
        cnt_ra = ptr_r[TW-1:0] + TW'(1);
        if (ctrl.phase == 2'd0) begin
          cnt_ra = ptr_r[TW-1:0];
        end else begin
          st_we  = 1'b1;
          cur_we = 1'b1;
          acc_nxt = acc_r + count_q;
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      iicb_pkg::OP_SCAT: begin
        case (ctrl.phase)
          2'd0: ;  // staged token read in flight
          2'd1: begin
            tok_term_nxt = stg_q[iicb_pkg::STGW-1 -: TW];
            tok_ent_nxt  = stg_q[iicb_pkg::ENTW-1:0];
          end
          2'd2: ;  // cursor read in flight
          default: begin
            lst_we = 1'b1;
            cur_we = 1'b1;
            cur_wa = tok_term_r;
            cur_wd = cur_q + CW'(1);
            ptr_nxt = ptr_r + 1'b1;
          end
        endcase
      end
      default: ;
    endcase
    // restart of a sweep wins over any step of the same cycle
    if (ctrl.first) begin
      ptr_nxt = '0;
      acc_nxt = '0;
    end
    total_nxt = total_r;
    if (total_clr) total_nxt = '0;
    else if (total_inc) total_nxt = total_r + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      ptr_r   <= '0;
    end else begin
      total_r <= total_nxt;
      ptr_r   <= ptr_nxt;
    end
    acc_r <= acc_nxt;
    tok_term_r <= tok_term_nxt;
    tok_ent_r <= tok_ent_nxt;
    add_r <= add_nxt;
  end

  always_comb begin
    stat.total = total_r;
    stat.sweep_done = 1'b0;
    case (ctrl.op)
      iicb_pkg::OP_CLR:  stat.sweep_done = (ptr_r == (XW+1)'(iicb_pkg::TERMS - 1));
      iicb_pkg::OP_PSUM: stat.sweep_done = (ptr_r == (XW+1)'(iicb_pkg::TERMS - 1));
      iicb_pkg::OP_SCAT: stat.sweep_done = (ptr_r + 1'b1 >= (XW+1)'(total_r));
      default: ;
    endcase
  end

  iicb_ram #(.WIDTH(CW), .DEPTH(iicb_pkg::TERMS)) u_counts (
    .clk, .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd), .raddr(cnt_ra), .rdata(count_q));
  iicb_ram #(.WIDTH(CW), .DEPTH(iicb_pkg::TERMS)) u_starts (
    .clk, .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(start_q));
  iicb_ram #(.WIDTH(CW), .DEPTH(iicb_pkg::TERMS)) u_cursors (
    .clk, .we(cur_we), .waddr(cur_wa), .wdata(cur_wd), .raddr(cur_ra), .rdata(cur_q));
  iicb_ram #(.WIDTH(iicb_pkg::STGW), .DEPTH(iicb_pkg::TOKENS)) u_staged (
    .clk, .we(stg_we), .waddr(stg_wa), .wdata(stg_wd), .raddr(stg_ra), .rdata(stg_q));
  iicb_ram #(.WIDTH(iicb_pkg::ENTW), .DEPTH(iicb_pkg::TOKENS)) u_lists (
    .clk, .we(lst_we), .waddr(lst_wa), .wdata(lst_wd), .raddr(lst_ra), .rdata(ent_q));
endmodule

[src/iicb_ctrl.sv]
// command decode and sequencing for the index builder
module iicb_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  in_cmd,
  input  logic [iicb_pkg::XW-1:0]     in_entry_index,
  output iicb_pkg::ctrl_t             ctrl,
  input  iicb_pkg::stat_t             stat,
  output logic                        total_clr,
  output logic                        total_inc,
  output logic                        out_strobe,
  output logic [1:0]                  out_status,
  output logic                        sel_ent,
  output logic                        sel_trm
);
  typedef enum logic [2:0] {
    S_IDLE, S_ADD, S_CLR, S_PSUM, S_SCAT, S_INIT
  } state_t;

  state_t         state_r, state_nxt;
  logic [1:0]     ph_r, ph_nxt;
  logic           built_r, built_nxt;
  logic           strobe_r, strobe_nxt;
  logic [1:0]     status_r, status_nxt;
  logic           sel_ent_r, sel_ent_nxt, sel_trm_r, sel_trm_nxt;
  logic           acc;

  assign acc = start && !busy;
  assign busy = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_status = status_r;
  assign sel_ent = sel_ent_r;
  assign sel_trm = sel_trm_r;

  always_comb begin
    state_nxt = state_r; ph_nxt = ph_r; built_nxt = built_r;
    strobe_nxt = 1'b0; status_nxt = status_r;
    sel_ent_nxt = 1'b0; sel_trm_nxt = 1'b0;
    ctrl.op = iicb_pkg::OP_IDLE; ctrl.step = 1'b0; ctrl.first = 1'b0; ctrl.phase = ph_r;
    total_clr = 1'b0; total_inc = 1'b0;
    case (state_r)
      S_IDLE: begin
        ctrl.first = 1'b1;
        ph_nxt = '0;
        if (acc) begin
          status_nxt = iicb_pkg::ST_OK;
          case (in_cmd)
            iicb_pkg::CMD_ADD: begin
              // term range always holds at the field width of this configuration
              if (built_r) begin
                status_nxt = iicb_pkg::ST_PHASE; strobe_nxt = 1'b1;
              end else if (stat.total >= iicb_pkg::CW'(iicb_pkg::TOKENS)) begin
                status_nxt = iicb_pkg::ST_FULL; strobe_nxt = 1'b1;
              end else begin
                ctrl.op = iicb_pkg::OP_ADD_RD;
                state_nxt = S_ADD;
              end
            end
            iicb_pkg::CMD_BUILD: begin
              if (built_r) begin
                status_nxt = iicb_pkg::ST_PHASE; strobe_nxt = 1'b1;
              end else begin
                state_nxt = S_PSUM;
              end
            end
            iicb_pkg::CMD_RDENT: begin
              if (!built_r) begin
                status_nxt = iicb_pkg::ST_PHASE; strobe_nxt = 1'b1;
              end else if (iicb_pkg::CW'(in_entry_index) >= stat.total) begin
                status_nxt = iicb_pkg::ST_RANGE; strobe_nxt = 1'b1;
              end else begin
                // registered ram read lands in the strobe cycle
                ctrl.op = iicb_pkg::OP_RDENT;
                sel_ent_nxt = 1'b1;
                strobe_nxt = 1'b1;
              end
            end
            iicb_pkg::CMD_RDTRM: begin
              if (!built_r) begin
                status_nxt = iicb_pkg::ST_PHASE; strobe_nxt = 1'b1;
              end else begin
                ctrl.op = iicb_pkg::OP_RDTRM;
                sel_trm_nxt = 1'b1;
                strobe_nxt = 1'b1;
              end
            end
            iicb_pkg::CMD_CLEAR: begin
              total_clr = 1'b1;
              built_nxt = 1'b0;
              state_nxt = S_CLR;
            end
            default: strobe_nxt = 1'b1;
          endcase
        end
      end
      S_ADD: begin
        ctrl.op = iicb_pkg::OP_ADD_WR;
        total_inc = 1'b1;
        strobe_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_INIT, S_CLR: begin
        ctrl.op = iicb_pkg::OP_CLR;
        ctrl.step = 1'b1;
        if (stat.sweep_done) begin
          state_nxt = S_IDLE;
          strobe_nxt = (state_r == S_CLR);
          status_nxt = iicb_pkg::ST_OK;
        end
      end
      S_PSUM: begin
        ctrl.op = iicb_pkg::OP_PSUM;
        ph_nxt = 2'd1;
        if (ph_r != 2'd0 && stat.sweep_done) begin
          ctrl.first = 1'b0;
          ph_nxt = 2'd0;
          if (stat.total == '0) begin
            built_nxt = 1'b1; strobe_nxt = 1'b1; state_nxt = S_IDLE;
          end else begin
            state_nxt = S_SCAT;
          end
        end
      end
      S_SCAT: begin
        ctrl.op = iicb_pkg::OP_SCAT;
        ctrl.first = (ph_r == 2'd0) && (state_r != S_SCAT);
        ph_nxt = ph_r + 2'd1;
        if (ph_r == 2'd3 && stat.sweep_done) begin
          built_nxt = 1'b1; strobe_nxt = 1'b1; state_nxt = S_IDLE;
          status_nxt = iicb_pkg::ST_OK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_PSUM && ph_nxt == 2'd0 && state_nxt == S_SCAT) ctrl.first = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      ph_r      <= '0;
      built_r   <= 1'b0;
      strobe_r  <= 1'b0;
      status_r  <= '0;
      sel_ent_r <= 1'b0;
      sel_trm_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ph_r      <= ph_nxt;
      built_r   <= built_nxt;
      strobe_r  <= strobe_nxt;
      status_r  <= status_nxt;
      sel_ent_r <= sel_ent_nxt;
      sel_trm_r <= sel_trm_nxt;
    end
  end

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> state_r == S_IDLE)
    else $error("result strobe outside idle");
  a_sel_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (sel_ent_r || sel_trm_r) |-> strobe_r)
    else $error("read data selected without result");
  a_add_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADD |=> strobe_r && state_r == S_IDLE)
    else $error("add did not complete");
  a_build_flag: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(built_r) |-> strobe_r)
    else $error("build finished without result");
endmodule

[src/inverted_index_counting_build_unit.sv]
// top level of the inverted index counting build unit
// Commands are taken when start is high and busy low; each gives one result on
// out_strobe for a single cycle, which the receiver cannot stall. Add keeps busy high
// for the count write (count read, then write) and gives its result the cycle after.
// Reads and rejected commands keep busy low and give their result in the cycle after
// the accept. Build runs one prefix step per term, then per staged token a staged
// memory read, a cursor read and a list write with cursor increment. Clear sweeps the
// count memory; the same sweep runs after reset with busy high.
module inverted_index_counting_build_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [9:0]  in_term_id,
  input  logic [15:0] in_doc_id,
  input  logic [9:0]  in_token_pos,
  input  logic [11:0] in_entry_index,
  output logic        out_strobe,
  output logic [15:0] out_entry_doc,
  output logic [9:0]  out_entry_pos,
  output logic [12:0] out_list_start,
  output logic [12:0] out_list_length,
  output logic [1:0]  out_status
);
  iicb_pkg::ctrl_t ctrl;
  iicb_pkg::stat_t stat;
  logic total_clr, total_inc, sel_ent, sel_trm;
  logic [iicb_pkg::ENTW-1:0] ent_q;
  logic [iicb_pkg::CW-1:0]   start_q, count_q;

  iicb_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_entry_index, .ctrl, .stat,
    .total_clr, .total_inc, .out_strobe, .out_status, .sel_ent, .sel_trm);

  iicb_datapath u_dp (
    .clk, .rst_n, .ctrl, .stat, .total_clr, .total_inc, .in_term_id, .in_doc_id,
    .in_token_pos, .in_entry_index, .ent_q, .start_q, .count_q);

  assign out_entry_doc   = sel_ent ? ent_q[iicb_pkg::ENTW-1 -: 16] : '0;
  assign out_entry_pos   = sel_ent ? ent_q[9:0] : '0;
  assign out_list_start  = sel_trm ? start_q : '0;
  assign out_list_length = sel_trm ? count_q : '0;
endmodule
